>>> rtl/core/pdmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdmc_pkg
// shared types, codes and reset values of the panel display mode controller
// ----------------------------------------------------------------------------
package pdmc_pkg;

	localparam int PRESCALE_BITS_DEF = 8;
	localparam int TIMER_BITS_DEF    = 19;

	localparam int CFG_TIME_W  = 19;
	localparam int CFG_PRESS_W = 8;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 32;

	localparam logic [CFG_TIME_W-1:0]  ACT_TIMEOUT_RST = 19'd320000;
	localparam logic [CFG_TIME_W-1:0]  HOLD_TIME_RST   = 19'd320000;
	localparam logic [CFG_PRESS_W-1:0] SHORT_MIN_RST   = 8'd5;
	localparam logic [CFG_PRESS_W-1:0] SHORT_MAX_RST   = 8'd18;
	localparam logic [CFG_PRESS_W-1:0] LONG_THR_RST    = 8'd65;

	localparam logic [7:0] PRESS_SAT = 8'hff;

	// register indexes
	localparam logic [2:0] REG_ACT_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_HOLD_TIME   = 3'd1;
	localparam logic [2:0] REG_SHORT_MIN   = 3'd2;
	localparam logic [2:0] REG_SHORT_MAX   = 3'd3;
	localparam logic [2:0] REG_LONG_THR    = 3'd4;

	// event flag bit positions
	localparam int EV_USB    = 0;
	localparam int EV_HOST   = 1;
	localparam int EV_TX     = 2;
	localparam int EV_RX     = 3;
	localparam int EV_ABDONE = 4;

	typedef enum logic [2:0] {
		M_UNCONF = 3'd0,
		M_NONUM  = 3'd1,
		M_NUM    = 3'd2,
		M_NUM_D  = 3'd3,
		M_ACT    = 3'd4,
		M_BAUD   = 3'd5
	} ui_state_t;

	typedef enum logic [2:0] {
		D_TEST   = 3'd0,
		D_WAIT   = 3'd1,
		D_NUMBER = 3'd2,
		D_ACT    = 3'd3,
		D_BAUD   = 3'd4
	} disp_mode_t;

	typedef struct packed {
		logic [CFG_TIME_W-1:0]  act_timeout;
		logic [CFG_TIME_W-1:0]  hold_time;
		logic [CFG_PRESS_W-1:0] short_min;
		logic [CFG_PRESS_W-1:0] short_max;
		logic [CFG_PRESS_W-1:0] long_thr;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/pdmc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdmc_cfg_regs
// apb register bank holding timeouts and button press thresholds
// ----------------------------------------------------------------------------
module pdmc_cfg_regs (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [pdmc_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire  [pdmc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pdmc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output pdmc_pkg::cfg_t                   cfg
);
	import pdmc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.act_timeout <= ACT_TIMEOUT_RST;
			cfg_q.hold_time   <= HOLD_TIME_RST;
			cfg_q.short_min   <= SHORT_MIN_RST;
			cfg_q.short_max   <= SHORT_MAX_RST;
			cfg_q.long_thr    <= LONG_THR_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ACT_TIMEOUT: cfg_q.act_timeout <= pwdata[CFG_TIME_W-1:0];
				REG_HOLD_TIME:   cfg_q.hold_time   <= pwdata[CFG_TIME_W-1:0];
				REG_SHORT_MIN:   cfg_q.short_min   <= pwdata[CFG_PRESS_W-1:0];
				REG_SHORT_MAX:   cfg_q.short_max   <= pwdata[CFG_PRESS_W-1:0];
				REG_LONG_THR:    cfg_q.long_thr    <= pwdata[CFG_PRESS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ACT_TIMEOUT: prdata = APB_DATA_W'(cfg_q.act_timeout);
			REG_HOLD_TIME:   prdata = APB_DATA_W'(cfg_q.hold_time);
			REG_SHORT_MIN:   prdata = APB_DATA_W'(cfg_q.short_min);
			REG_SHORT_MAX:   prdata = APB_DATA_W'(cfg_q.short_max);
			REG_LONG_THR:    prdata = APB_DATA_W'(cfg_q.long_thr);
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/panel_display_mode_controller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// panel_display_mode_controller_unit
// button sampling, display mode state machine and autobaud strobes
// path from input transfer to result: input register then result register
// throughput: one tick per cycle while the result side takes every result
// reset: state machine unconfigured, timer, prescaler and press count zero,
// display test mode, registers at their default values
// ----------------------------------------------------------------------------
module panel_display_mode_controller_unit #(
	parameter int PRESCALE_BITS = pdmc_pkg::PRESCALE_BITS_DEF,
	parameter int TIMER_BITS    = pdmc_pkg::TIMER_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [pdmc_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire  [pdmc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pdmc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [4:0]                       event_flags,
	input  wire                              button_level,
	input  wire                              set_port,
	input  wire  [7:0]                       new_port_number,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [2:0]                       display_mode,
	output logic [7:0]                       display_value,
	output logic                             value_written,
	output logic                             baud_start,
	output logic                             baud_stop,
	output logic                             short_press,
	output logic [2:0]                       ui_mode
);
	import pdmc_pkg::*;

	cfg_t cfg;

	pdmc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic       valid_s1;
	logic [4:0] ev_s1;
	logic       btn_s1;
	logic       set_s1;
	logic [7:0] num_s1;
	logic       adv;

	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ev_s1  <= event_flags;
			btn_s1 <= button_level;
			set_s1 <= set_port;
			num_s1 <= new_port_number;
		end
	end

	// state
	ui_state_t               ms_q, ms_n;
	disp_mode_t              sm_q, sm_n;
	logic [7:0]              sv_q, sv_n;
	logic [TIMER_BITS-1:0]   cd_q, cd_n, cd_dec;
	logic [PRESCALE_BITS-1:0] presc_q, presc_n;
	logic [7:0]              pc_q, pc_n;
	logic [7:0]              port_q, port_eff;
	logic [TIMER_BITS-1:0]   act_load, hold_load;
	logic                    sample, long_ev, short_ev;
	logic                    wv, eng, abt;

	assign act_load  = TIMER_BITS'(cfg.act_timeout);
	assign hold_load = TIMER_BITS'(cfg.hold_time);
	assign port_eff  = set_s1 ? num_s1 : port_q;
	assign cd_dec    = (cd_q != '0) ? cd_q - 1'b1 : cd_q;
	assign presc_n   = presc_q + 1'b1;
	assign sample    = (presc_n == '0);

	// button sampling
	always_comb begin
		pc_n     = pc_q;
		long_ev  = 1'b0;
		short_ev = 1'b0;
		if (sample) begin
			if (!btn_s1) begin
				if (pc_q > cfg.long_thr && pc_q != PRESS_SAT) begin
					long_ev = 1'b1;
					pc_n    = PRESS_SAT;
				end else if (pc_q != PRESS_SAT) begin
					pc_n = pc_q + 8'd1;
				end
			end else begin
				short_ev = (pc_q > cfg.short_min) && (pc_q < cfg.short_max);
				pc_n     = '0;
			end
		end
	end

	// display mode state machine
	always_comb begin
		ms_n = ms_q;
		sm_n = sm_q;
		sv_n = sv_q;
		cd_n = cd_dec;
		wv   = 1'b0;
		eng  = 1'b0;
		abt  = 1'b0;
		case (ms_q)
			M_UNCONF: begin
				if (ev_s1[EV_USB]) begin
					ms_n = M_NONUM;
					sm_n = D_WAIT;
				end
			end
			M_NONUM: begin
				if (long_ev) begin
					ms_n = M_BAUD;
					sm_n = D_BAUD;
					eng  = 1'b1;
				end else if (ev_s1[EV_HOST]) begin
					sm_n = D_NUMBER;
					sv_n = port_eff;
					wv   = 1'b1;
					cd_n = hold_load;
					ms_n = M_NUM_D;
				end
				if (ev_s1[EV_TX] || ev_s1[EV_RX]) begin
					ms_n = M_ACT;
					sm_n = D_ACT;
					cd_n = act_load;
				end
			end
			M_NUM, M_NUM_D: begin
				if (long_ev) begin
					ms_n = M_BAUD;
					sm_n = D_BAUD;
					eng  = 1'b1;
				end else if (ev_s1[EV_TX]) begin
					ms_n = M_ACT;
					sm_n = D_ACT;
					cd_n = act_load;
				end
				if (ms_n == M_NUM) begin
					if (ev_s1[EV_RX]) begin
						ms_n = M_ACT;
						sm_n = D_ACT;
						cd_n = act_load;
					end
				end else if (ev_s1[EV_RX] && cd_n == '0) begin
					ms_n = M_ACT;
					sm_n = D_ACT;
					cd_n = act_load;
				end
			end
			M_ACT: begin
				if (long_ev) begin
					ms_n = M_BAUD;
					sm_n = D_BAUD;
					eng  = 1'b1;
				end else if (ev_s1[EV_HOST]) begin
					sm_n = D_NUMBER;
					sv_n = port_eff;
					wv   = 1'b1;
					cd_n = '0;
					ms_n = M_NUM;
				end else if (cd_dec != '0) begin
					sv_n = {4'b0, ev_s1[EV_RX], ev_s1[EV_TX], 2'b0};
					wv   = 1'b1;
					if (ev_s1[EV_TX] || ev_s1[EV_RX]) begin
						cd_n = act_load;
					end
				end else if (port_eff == '0) begin
					ms_n = M_NONUM;
					sm_n = D_WAIT;
				end else begin
					sm_n = D_NUMBER;
					sv_n = port_eff;
					wv   = 1'b1;
					cd_n = '0;
					ms_n = M_NUM;
				end
			end
			M_BAUD: begin
				if (long_ev || ev_s1[EV_ABDONE]) begin
					abt = 1'b1;
					if (port_eff == '0) begin
						ms_n = M_NONUM;
						sm_n = D_WAIT;
					end else begin
						sm_n = D_NUMBER;
						sv_n = port_eff;
						wv   = 1'b1;
						cd_n = '0;
						ms_n = M_NUM;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q    <= M_UNCONF;
			sm_q    <= D_TEST;
			sv_q    <= '0;
			cd_q    <= '0;
			presc_q <= '0;
			pc_q    <= '0;
			port_q  <= '0;
		end else if (adv) begin
			ms_q    <= ms_n;
			sm_q    <= sm_n;
			sv_q    <= sv_n;
			cd_q    <= cd_n;
			presc_q <= presc_n;
			pc_q    <= pc_n;
			port_q  <= port_eff;
		end
	end

	// result register
	logic [2:0] mode_s2, ui_s2;
	logic [7:0] value_s2;
	logic       wv_s2, eng_s2, abt_s2, short_s2, valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2  <= sm_n;
			value_s2 <= sv_n;
			wv_s2    <= wv;
			eng_s2   <= eng;
			abt_s2   <= abt;
			short_s2 <= short_ev;
			ui_s2    <= ms_n;
		end
	end

	assign out_valid     = valid_s2;
	assign display_mode  = mode_s2;
	assign display_value = value_s2;
	assign value_written = wv_s2;
	assign baud_start    = eng_s2;
	assign baud_stop     = abt_s2;
	assign short_press   = short_s2;
	assign ui_mode       = ui_s2;

	a_strobes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(baud_start && baud_stop))
		else $error("engage and abort in one result");

	a_abort_leaves_baud: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && baud_stop) |-> (ui_mode == M_NONUM || ui_mode == M_NUM))
		else $error("abort without return to number view");

	a_baud_display: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ui_mode == M_BAUD) |-> (display_mode == D_BAUD))
		else $error("baud state without baud display");

	a_no_unconf_return: assert property (@(posedge clk) disable iff (!arst_n)
		(ms_q != M_UNCONF) |=> (ms_q != M_UNCONF))
		else $error("state machine returned to unconfigured");

endmodule
`default_nettype wire

>>> verif/tb_panel_display_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_panel_display_mode_controller_unit
// self-checking bench: a directed table from reset, then random button and
// event traffic over several register settings, every result transfer
// compared with a table row or an in-bench model of mode machine and button timer
// ----------------------------------------------------------------------------
module tb_panel_display_mode_controller_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pdmc_pkg::*;

	localparam int TW = TIMER_BITS_DEF;
	localparam int PW = PRESCALE_BITS_DEF;

	localparam logic [4:0] F_NONE = 5'd0;
	localparam logic [4:0] F_USB  = 5'(1 << EV_USB);
	localparam logic [4:0] F_HOST = 5'(1 << EV_HOST);
	localparam logic [4:0] F_TX   = 5'(1 << EV_TX);
	localparam logic [4:0] F_RX   = 5'(1 << EV_RX);
	localparam logic [4:0] F_ABD  = 5'(1 << EV_ABDONE);
	localparam logic [4:0] F_ALL  = F_USB | F_HOST | F_TX | F_RX | F_ABD;

	localparam logic [2:0] REG_UNUSED = 3'd5;
	localparam logic [2:0] REG_LIST [5] = '{REG_ACT_TIMEOUT, REG_HOLD_TIME,
		REG_SHORT_MIN, REG_SHORT_MAX, REG_LONG_THR};

	typedef struct packed {
		logic [4:0] flags;
		logic       button;
		logic       set_port;
		logic [7:0] port_num;
	} panel_tick_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] value;
		logic       written;
		logic       ab_engage;
		logic       ab_abort;
		logic       press_short;
		logic [2:0] ui;
	} panel_view_t;

	typedef struct packed {
		panel_tick_t tick;
		logic        typed;
		panel_view_t view;
	} directed_row_t;

	localparam panel_view_t NO_VIEW = '0;

	localparam directed_row_t DIR_ROWS [20] = '{
		'{'{F_NONE, 1'b1, 1'b0, 8'h00}, 1'b1,
			'{D_TEST, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, M_UNCONF}},
		'{'{F_HOST | F_TX | F_RX | F_ABD, 1'b0, 1'b1, 8'hff}, 1'b1,
			'{D_TEST, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, M_UNCONF}},
		'{'{F_USB, 1'b1, 1'b0, 8'h00}, 1'b1,
			'{D_WAIT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, M_NONUM}},
		'{'{F_HOST | F_TX, 1'b1, 1'b0, 8'h55}, 1'b1,
			'{D_ACT, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0, M_ACT}},
		'{'{F_HOST, 1'b0, 1'b0, 8'haa}, 1'b1,
			'{D_NUMBER, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0, M_NUM}},
		'{'{F_TX | F_RX, 1'b1, 1'b0, 8'h00}, 1'b1,
			'{D_ACT, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0, M_ACT}},
		'{'{F_TX | F_RX, 1'b1, 1'b0, 8'h00}, 1'b1,
			'{D_ACT, 8'h0c, 1'b1, 1'b0, 1'b0, 1'b0, M_ACT}},
		'{'{F_NONE, 1'b1, 1'b0, 8'h00}, 1'b1,
			'{D_ACT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, M_ACT}},
		'{'{F_ALL, 1'b1, 1'b0, 8'h00}, 1'b1,
			'{D_NUMBER, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0, M_NUM}},
		'{'{F_RX, 1'b1, 1'b1, 8'h00}, 1'b1,
			'{D_ACT, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0, M_ACT}},
		'{'{F_HOST, 1'b1, 1'b0, 8'h12}, 1'b1,
			'{D_NUMBER, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, M_NUM}},
		'{'{F_ABD, 1'b1, 1'b0, 8'h00}, 1'b1,
			'{D_NUMBER, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, M_NUM}},
		'{'{F_USB, 1'b0, 1'b1, 8'h81}, 1'b0, NO_VIEW},
		'{'{F_TX, 1'b1, 1'b0, 8'h7e}, 1'b0, NO_VIEW},
		'{'{F_RX, 1'b0, 1'b0, 8'h00}, 1'b0, NO_VIEW},
		'{'{F_TX, 1'b1, 1'b1, 8'h01}, 1'b0, NO_VIEW},
		'{'{F_HOST | F_ABD, 1'b1, 1'b0, 8'h00}, 1'b0, NO_VIEW},
		'{'{F_USB | F_RX | F_ABD, 1'b0, 1'b1, 8'hfe}, 1'b0, NO_VIEW},
		'{'{F_ALL, 1'b1, 1'b0, 8'h3c}, 1'b0, NO_VIEW},
		'{'{F_NONE, 1'b1, 1'b0, 8'hc3}, 1'b0, NO_VIEW}
	};

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [4:0]            event_flags = '0;
	logic                  button_level = 1'b1;
	logic                  set_port = 1'b0;
	logic [7:0]            new_port_number = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            display_mode;
	logic [7:0]            display_value;
	logic                  value_written;
	logic                  baud_start;
	logic                  baud_stop;
	logic                  short_press;
	logic [2:0]            ui_mode;

	panel_display_mode_controller_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.event_flags(event_flags),
		.button_level(button_level),
		.set_port(set_port),
		.new_port_number(new_port_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.display_mode(display_mode),
		.display_value(display_value),
		.value_written(value_written),
		.baud_start(baud_start),
		.baud_stop(baud_stop),
		.short_press(short_press),
		.ui_mode(ui_mode)
	);

	// model state
	cfg_t             cfg;
	ui_state_t        ui_st;
	disp_mode_t       disp_st;
	logic [TW-1:0]    hold_timer;
	logic [PW-1:0]    sample_div;
	logic [7:0]       presses;
	logic [7:0]       port_no;
	logic [7:0]       disp_val;
	bit               val_wr, eng_strobe, abort_strobe;

	panel_view_t      expected_views [$];
	int               fails = 0;
	bit               calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("** panel_display_mode_controller_unit: FAILED **");
		$finish;
	end

	function automatic void write_value(input logic [7:0] v);
		disp_val = v;
		val_wr = 1'b1;
	endfunction

	function automatic void show_number(input bit delayed);
		disp_st = D_NUMBER;
		write_value(port_no);
		hold_timer = delayed ? TW'(cfg.hold_time) : '0;
		ui_st = delayed ? M_NUM_D : M_NUM;
	endfunction

	function automatic void show_wait();
		ui_st = M_NONUM;
		disp_st = D_WAIT;
	endfunction

	function automatic void show_port_view();
		if (port_no == 8'h00) show_wait();
		else show_number(1'b0);
	endfunction

	function automatic void show_activity();
		ui_st = M_ACT;
		disp_st = D_ACT;
		hold_timer = TW'(cfg.act_timeout);
	endfunction

	function automatic void start_baud();
		ui_st = M_BAUD;
		disp_st = D_BAUD;
		eng_strobe = 1'b1;
	endfunction

	function automatic panel_view_t advance_panel(input panel_tick_t t);
		panel_view_t v;
		bit long_ev, short_ev;
		logic [7:0] act_bits;
		long_ev = 1'b0;
		short_ev = 1'b0;
		val_wr = 1'b0;
		eng_strobe = 1'b0;
		abort_strobe = 1'b0;
		act_bits = 8'(t.flags & (F_TX | F_RX));
		if (t.set_port) port_no = t.port_num;
		if (hold_timer != '0) hold_timer--;
		sample_div++;
		if (sample_div == '0) begin
			if (!t.button) begin
				if (presses != PRESS_SAT && presses > cfg.long_thr) begin
					long_ev = 1'b1;
					presses = PRESS_SAT;
				end else if (presses != PRESS_SAT) begin
					presses++;
				end
			end else begin
				short_ev = (presses > cfg.short_min) && (presses < cfg.short_max);
				presses = '0;
			end
		end
		case (ui_st)
			M_UNCONF: begin
				if (t.flags[EV_USB]) show_wait();
			end
			M_NONUM: begin
				if (long_ev) start_baud();
				else if (t.flags[EV_HOST]) show_number(1'b1);
				if (act_bits != 8'h00) show_activity();
			end
			M_NUM, M_NUM_D: begin
				if (long_ev) start_baud();
				else if (t.flags[EV_TX]) show_activity();
				// the rx check sees the state left by the first decision
				if (ui_st == M_NUM) begin
					if (t.flags[EV_RX]) show_activity();
				end else if (t.flags[EV_RX] && hold_timer == '0) begin
					show_activity();
				end
			end
			M_ACT: begin
				if (long_ev) begin
					start_baud();
				end else if (t.flags[EV_HOST]) begin
					show_number(1'b0);
				end else if (hold_timer != '0) begin
					write_value(act_bits);
					if (act_bits != 8'h00) hold_timer = TW'(cfg.act_timeout);
				end else begin
					show_port_view();
				end
			end
			M_BAUD: begin
				if (long_ev || t.flags[EV_ABDONE]) begin
					abort_strobe = 1'b1;
					show_port_view();
				end
			end
			default: ;
		endcase
		v.mode = disp_st;
		v.value = disp_val;
		v.written = val_wr;
		v.ab_engage = eng_strobe;
		v.ab_abort = abort_strobe;
		v.press_short = short_ev;
		v.ui = ui_st;
		return v;
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		panel_view_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_views.size() == 0) begin
				$error("result transfer with nothing expected");
				fails++;
			end else begin
				want = expected_views.pop_front();
				compare_field("display_mode", 8'(want.mode), 8'(display_mode));
				compare_field("display_value", want.value, display_value);
				compare_field("value_written", 8'(want.written), 8'(value_written));
				compare_field("baud_start", 8'(want.ab_engage), 8'(baud_start));
				compare_field("baud_stop", 8'(want.ab_abort), 8'(baud_stop));
				compare_field("short_press", 8'(want.press_short), 8'(short_press));
				compare_field("ui_mode", 8'(want.ui), 8'(ui_mode));
			end
		end
		out_ready <= calm || ($urandom_range(0, 99) >= 25);
	end

	task automatic send_tick(input panel_tick_t t, input logic typed, input panel_view_t view);
		int gap;
		panel_view_t pv;
		if (!calm && $urandom_range(0, 99) < 12) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		event_flags <= t.flags;
		button_level <= t.button;
		set_port <= t.set_port;
		new_port_number <= t.port_num;
		do @(posedge clk); while (!in_ready);
		pv = advance_panel(t);
		expected_views.push_back(typed ? view : pv);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ACT_TIMEOUT: cfg.act_timeout = data[CFG_TIME_W-1:0];
			REG_HOLD_TIME:   cfg.hold_time = data[CFG_TIME_W-1:0];
			REG_SHORT_MIN:   cfg.short_min = data[CFG_PRESS_W-1:0];
			REG_SHORT_MAX:   cfg.short_max = data[CFG_PRESS_W-1:0];
			REG_LONG_THR:    cfg.long_thr = data[CFG_PRESS_W-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_check(input logic [2:0] idx);
		logic [31:0] want;
		case (idx)
			REG_ACT_TIMEOUT: want = 32'(cfg.act_timeout);
			REG_HOLD_TIME:   want = 32'(cfg.hold_time);
			REG_SHORT_MIN:   want = 32'(cfg.short_min);
			REG_SHORT_MAX:   want = 32'(cfg.short_max);
			default:         want = 32'(cfg.long_thr);
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("prdata at 0x%0h: expected %0h, got %0h", {idx, 2'b00}, want, prdata);
			fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only once every result has been transferred
	task automatic set_phase(input logic [18:0] act, input logic [18:0] hold,
		input logic [7:0] smin, input logic [7:0] smax, input logic [7:0] lthr);
		in_valid <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
		@(posedge clk);
		reg_write(REG_ACT_TIMEOUT, {13'($urandom), act});
		reg_write(REG_HOLD_TIME, {13'($urandom), hold});
		reg_write(REG_SHORT_MIN, {24'($urandom), smin});
		reg_write(REG_SHORT_MAX, {24'($urandom), smax});
		reg_write(REG_LONG_THR, {24'($urandom), lthr});
		reg_write(REG_UNUSED, $urandom);
		foreach (REG_LIST[i]) reg_check(REG_LIST[i]);
	endtask

	// button held and released over whole sample periods plus a random part, sparse events between
	task automatic run_random(input int quota, input bit stretch);
		panel_tick_t t;
		int counted, btn_left, n, lo, hi;
		bit stretching;
		logic btn;
		counted = 0;
		btn = 1'b1;
		btn_left = $urandom_range(16, 300);
		stretching = 1'b0;
		while (counted < quota) begin
			if (btn_left <= 0) begin
				btn = ~btn;
				if (btn) begin
					n = $urandom_range(0, 3);
					stretching = 1'b0;
				end else if (stretch) begin
					// long enough to saturate the press count
					n = 260;
					stretching = 1'b1;
					stretch = 1'b0;
				end else begin
					lo = int'(cfg.short_min) + 1;
					hi = int'(cfg.short_max) - 1;
					case ($urandom_range(0, 3))
						0: n = (lo <= hi) ? int'($urandom_range(lo, hi)) : 1;
						1: n = int'(cfg.long_thr) + int'($urandom_range(1, 3));
						2: n = $urandom_range(0, 2);
						default: n = $urandom_range(1, 8);
					endcase
					if (n > 24) n = $urandom_range(0, 4);
				end
				btn_left = n * 256 + int'($urandom_range(0, 255));
			end
			btn_left--;
			t.flags = ($urandom_range(0, 99) < (stretching ? 1 : 8)) ?
				5'($urandom_range(1, 31)) : F_NONE;
			t.button = btn;
			t.set_port = ($urandom_range(0, 99) < 5);
			t.port_num = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
			send_tick(t, 1'b0, NO_VIEW);
			counted++;
		end
	endtask

	initial begin
		cfg = '{ACT_TIMEOUT_RST, HOLD_TIME_RST, SHORT_MIN_RST, SHORT_MAX_RST, LONG_THR_RST};
		ui_st = M_UNCONF;
		disp_st = D_TEST;
		hold_timer = '0;
		sample_div = '0;
		presses = '0;
		port_no = '0;
		disp_val = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (REG_LIST[i]) reg_check(REG_LIST[i]);

		foreach (DIR_ROWS[i]) send_tick(DIR_ROWS[i].tick, DIR_ROWS[i].typed, DIR_ROWS[i].view);
		run_random(150, 1'b0);

		set_phase(19'd40, 19'd25, 8'd0, 8'd3, 8'd1);
		calm = 1'b1;
		run_random(150, 1'b0);
		calm = 1'b0;

		set_phase(19'd0, 19'd0, 8'd0, 8'd254, 8'd0);
		run_random(150, 1'b0);

		set_phase(19'd300, 19'd600, 8'd2, 8'd6, 8'd4);
		run_random(150, 1'b0);

		set_phase(19'h7ffff, 19'h7ffff, 8'd254, 8'd254, 8'd254);
		run_random(150, 1'b1);

		set_phase(19'd12, 19'd5, 8'd254, 8'd0, 8'd0);
		run_random(150, 1'b0);

		in_valid <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("** panel_display_mode_controller_unit: PASSED **");
		else
			$display("** panel_display_mode_controller_unit: FAILED **");
		$finish;
	end

endmodule
